>>> design/mt64_pkg.sv
// Shared types, constants and functions of the MT19937-64 generator.
`timescale 1ns / 1ps

package mt64_pkg;

    // Generator geometry.
    localparam int unsigned N_WORDS = 312;
    localparam int unsigned M_OFFSET = 156;
    localparam logic [8:0] LAST_INDEX = 9'd311;

    // Twist and seeding constants.
    localparam logic [63:0] TWIST_MATRIX = 64'hB5026F5AA96619E9;
    localparam logic [63:0] UPPER_MASK = 64'hFFFFFFFF80000000;
    localparam logic [63:0] LOWER_MASK = 64'h000000007FFFFFFF;
    localparam logic [63:0] LIN_MULT = 64'd6364136223846793005;
    localparam logic [63:0] ARR1_MULT = 64'd3935559000370003845;
    localparam logic [63:0] ARR2_MULT = 64'd2862933555777941757;
    localparam logic [63:0] ARRAY_BASE_SEED = 64'd19650218;
    localparam logic [63:0] SEED_RESET = 64'd5489;
    localparam logic [63:0] FINAL_WORD0 = 64'h8000000000000000;
    localparam logic [2:0] KEY_COUNT_RESET = 3'd4;
    localparam logic [63:0] KEY_RESET [4] = '{
        64'h12345, 64'h23456, 64'h34567, 64'h45678
    };

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SEED_MODE  = 3'd0,
        CFG_SEED_VALUE = 3'd1,
        CFG_KEY_COUNT  = 3'd2,
        CFG_KEY_WORD0  = 3'd3,
        CFG_KEY_WORD1  = 3'd4,
        CFG_KEY_WORD2  = 3'd5,
        CFG_KEY_WORD3  = 3'd6,
        CFG_UNUSED     = 3'd7
    } cfg_idx_t;

    // Seeding phase: plain fill, base fill for array seeding, two array passes.
    typedef enum logic [1:0] {
        PH_LIN  = 2'd0,
        PH_PRE  = 2'd1,
        PH_ARR1 = 2'd2,
        PH_ARR2 = 2'd3
    } phase_t;

    // Store read address selection.
    typedef enum logic [1:0] {
        RD_SEED = 2'd0,
        RD_I    = 2'd1,
        RD_I1   = 2'd2,
        RD_IM   = 2'd3
    } rdsel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_START,
        ST_SEED_READ,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SEED_WRITE,
        ST_SEED_FINAL,
        ST_DRAW_RD0,
        ST_DRAW_RD1,
        ST_DRAW_RD2,
        ST_DRAW_TWIST
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       seed_start;
        logic       rd_en;
        rdsel_t     rd_sel;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       seed_wr;
        phase_t     phase;
        logic       arr_init;
        logic       arr2_init;
        logic       final_wr;
        logic       seed_done;
        logic       cap_a;
        logic       cap_b;
        logic       twist;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_last;
        logic seeded;
        logic seed_mode;
        logic out_full;
    } dp_status_t;

    // Output tempering.
    function automatic logic [63:0] temper(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ ((x >> 29) & 64'h5555555555555555);
        x = x ^ ((x << 17) & 64'h71D67FFFEDA60000);
        x = x ^ ((x << 37) & 64'hFFF7EEE000000000);
        x = x ^ (x >> 43);
        return x;
    endfunction

endpackage

>>> design/mt64_datapath.sv
// Datapath: state store, seeding arithmetic, twist, tempering and output register.
`timescale 1ns / 1ps

module mt64_datapath #(
    parameter int KEY_WORDS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mt64_pkg::dp_cmd_t    cmd,
    output mt64_pkg::dp_status_t status,
    input  logic                 seed_mode,
    input  logic [63:0]          seed_value,
    input  logic [2:0]           key_count,
    input  logic [63:0]          key_words [KEY_WORDS],
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [63:0]          random_word
);

    localparam int KIDX = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

    logic [63:0] mem [mt64_pkg::N_WORDS];
    logic [63:0] rd_data_reg;
    logic [8:0]  rd_addr;
    logic        wr_en;
    logic [8:0]  wr_addr;
    logic [63:0] wr_data;

    logic [63:0] p_reg, p_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] a_reg, b_reg;
    logic [8:0]  seed_idx_reg, seed_idx_next;
    logic [KIDX-1:0] key_idx_reg, key_idx_next;
    logic [8:0]  loop_cnt_reg, loop_cnt_next;
    logic [8:0]  word_idx_reg, word_idx_next;
    logic        seeded_reg, seeded_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_word_reg;

    logic [63:0] tmix, mult_c, seed_new, twisted, x;
    logic [31:0] op_a, op_b;
    logic [63:0] prod;
    logic [9:0]  idx_p1, idx_pm;
    logic [8:0]  idx_plus1, idx_plusm;
    logic [2:0]  key_len;
    logic [2:0]  key_idx_inc;

    // Wrapped neighbor indexes of the draw word.
    assign idx_p1 = {1'b0, word_idx_reg} + 10'd1;
    assign idx_pm = {1'b0, word_idx_reg} + 10'(mt64_pkg::M_OFFSET);
    assign idx_plus1 = (idx_p1 >= 10'(mt64_pkg::N_WORDS)) ?
                       9'(idx_p1 - 10'(mt64_pkg::N_WORDS)) : idx_p1[8:0];
    assign idx_plusm = (idx_pm >= 10'(mt64_pkg::N_WORDS)) ?
                       9'(idx_pm - 10'(mt64_pkg::N_WORDS)) : idx_pm[8:0];

    // Effective key length, clamped to 1..KEY_WORDS.
    always_comb
    begin
        if (key_count == 3'd0)
            key_len = 3'd1;
        else if (key_count > 3'(KEY_WORDS))
            key_len = 3'(KEY_WORDS);
        else
            key_len = key_count;
    end
    assign key_idx_inc = 3'(key_idx_reg) + 3'd1;

    // One 32x32 partial product per cycle of the seeding multiply.
    assign tmix = p_reg ^ (p_reg >> 62);
    always_comb
    begin
        unique case (cmd.phase)
            mt64_pkg::PH_ARR1: mult_c = mt64_pkg::ARR1_MULT;
            mt64_pkg::PH_ARR2: mult_c = mt64_pkg::ARR2_MULT;
            default:           mult_c = mt64_pkg::LIN_MULT;
        endcase
        op_a = (cmd.mul_step == 2'd2) ? tmix[63:32] : tmix[31:0];
        op_b = (cmd.mul_step == 2'd1) ? mult_c[63:32] : mult_c[31:0];
    end
    assign prod = {32'd0, op_a} * {32'd0, op_b};

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.mul_en)
        begin
            if (cmd.mul_step == 2'd0)
                acc_next = prod;
            else
                acc_next = acc_reg + {prod[31:0], 32'd0};
        end
    end

    // New word of the current seeding step.
    always_comb
    begin
        unique case (cmd.phase)
            mt64_pkg::PH_ARR1:
                seed_new = (rd_data_reg ^ acc_reg) + key_words[key_idx_reg]
                           + 64'(key_idx_reg);
            mt64_pkg::PH_ARR2:
                seed_new = (rd_data_reg ^ acc_reg) - 64'(seed_idx_reg);
            default:
                seed_new = acc_reg + 64'(seed_idx_reg);
        endcase
    end

    // Twist of the draw word and its tempered value.
    assign x = (a_reg & mt64_pkg::UPPER_MASK) | (b_reg & mt64_pkg::LOWER_MASK);
    assign twisted = rd_data_reg ^ (x >> 1) ^ (x[0] ? mt64_pkg::TWIST_MATRIX : 64'd0);

    // Counter and seeding register updates.
    always_comb
    begin
        p_next = p_reg;
        seed_idx_next = seed_idx_reg;
        key_idx_next = key_idx_reg;
        loop_cnt_next = loop_cnt_reg;
        word_idx_next = word_idx_reg;
        seeded_next = seeded_reg;
        if (cmd.seed_start)
        begin
            p_next = seed_mode ? mt64_pkg::ARRAY_BASE_SEED : seed_value;
            seed_idx_next = 9'd1;
            loop_cnt_next = mt64_pkg::LAST_INDEX;
            seeded_next = 1'b0;
        end
        if (cmd.seed_wr)
        begin
            p_next = seed_new;
            loop_cnt_next = loop_cnt_reg - 9'd1;
            if (seed_idx_reg == mt64_pkg::LAST_INDEX)
                seed_idx_next = 9'd1;
            else
                seed_idx_next = seed_idx_reg + 9'd1;
            if (cmd.phase == mt64_pkg::PH_ARR1)
                key_idx_next = (key_idx_inc >= key_len) ? '0 : KIDX'(key_idx_inc);
        end
        if (cmd.arr_init)
        begin
            p_next = mt64_pkg::ARRAY_BASE_SEED;
            seed_idx_next = 9'd1;
            key_idx_next = '0;
            loop_cnt_next = 9'(mt64_pkg::N_WORDS);
        end
        if (cmd.arr2_init)
            loop_cnt_next = mt64_pkg::LAST_INDEX;
        if (cmd.seed_done)
        begin
            word_idx_next = 9'd0;
            seeded_next = 1'b1;
        end
        if (cmd.twist)
            word_idx_next = idx_plus1;
    end

    // Store port selection.
    always_comb
    begin
        unique case (cmd.rd_sel)
            mt64_pkg::RD_SEED: rd_addr = seed_idx_reg;
            mt64_pkg::RD_I:    rd_addr = word_idx_reg;
            mt64_pkg::RD_I1:   rd_addr = idx_plus1;
            mt64_pkg::RD_IM:   rd_addr = idx_plusm;
            default:           rd_addr = word_idx_reg;
        endcase
        wr_en = 1'b1;
        wr_addr = 9'd0;
        wr_data = p_next;
        priority if (cmd.seed_start)
            wr_data = p_next;
        else if (cmd.final_wr)
            wr_data = mt64_pkg::FINAL_WORD0;
        else if (cmd.seed_wr)
        begin
            wr_addr = seed_idx_reg;
            wr_data = seed_new;
        end
        else if (cmd.twist)
        begin
            wr_addr = word_idx_reg;
            wr_data = twisted;
        end
        else
            wr_en = 1'b0;
    end

    // State store, written and read once per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Output register: holds while stalled, refilled by a twist.
    assign out_valid_next = cmd.twist ? 1'b1 : (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            word_idx_reg <= 9'd0;
            seed_idx_reg <= 9'd1;
            key_idx_reg <= '0;
            loop_cnt_reg <= 9'd1;
        end
        else
        begin
            seeded_reg <= seeded_next;
            out_valid_reg <= out_valid_next;
            word_idx_reg <= word_idx_next;
            seed_idx_reg <= seed_idx_next;
            key_idx_reg <= key_idx_next;
            loop_cnt_reg <= loop_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        acc_reg <= acc_next;
        if (cmd.cap_a)
            a_reg <= rd_data_reg;
        if (cmd.cap_b)
            b_reg <= rd_data_reg;
        if (cmd.twist)
            out_word_reg <= mt64_pkg::temper(twisted);
    end

    assign status.cnt_last = (loop_cnt_reg == 9'd1);
    assign status.seeded = seeded_reg;
    assign status.seed_mode = seed_mode;
    assign status.out_full = out_valid_reg & out_stall;

    assign out_valid = out_valid_reg;
    assign random_word = out_word_reg;

endmodule

>>> design/mt64_controller.sv
// Controller: sequences seeding and draws over the shared datapath.
`timescale 1ns / 1ps

module mt64_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 restart,
    output logic                 in_stall,
    input  mt64_pkg::dp_status_t status,
    output mt64_pkg::dp_cmd_t    cmd
);

    mt64_pkg::state_t state_reg, state_next;
    mt64_pkg::phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mt64_pkg::ST_IDLE;
            phase_reg <= mt64_pkg::PH_LIN;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd = '0;
        cmd.phase = phase_reg;
        cmd.rd_sel = mt64_pkg::RD_SEED;
        in_stall = 1'b1;
        unique case (state_reg)
            mt64_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (restart || !status.seeded)
                        state_next = mt64_pkg::ST_SEED_START;
                    else
                        state_next = mt64_pkg::ST_DRAW_RD0;
                end
            end
            mt64_pkg::ST_SEED_START:
            begin
                cmd.seed_start = 1'b1;
                phase_next = status.seed_mode ? mt64_pkg::PH_PRE : mt64_pkg::PH_LIN;
                state_next = mt64_pkg::ST_MUL0;
            end
            mt64_pkg::ST_SEED_READ:
            begin
                cmd.rd_en = 1'b1;
                state_next = mt64_pkg::ST_MUL0;
            end
            mt64_pkg::ST_MUL0:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_step = 2'd0;
                state_next = mt64_pkg::ST_MUL1;
            end
            mt64_pkg::ST_MUL1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_step = 2'd1;
                state_next = mt64_pkg::ST_MUL2;
            end
            mt64_pkg::ST_MUL2:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_step = 2'd2;
                state_next = mt64_pkg::ST_SEED_WRITE;
            end
            mt64_pkg::ST_SEED_WRITE:
            begin
                cmd.seed_wr = 1'b1;
                if (!status.cnt_last)
                begin
                    if (phase_reg == mt64_pkg::PH_LIN || phase_reg == mt64_pkg::PH_PRE)
                        state_next = mt64_pkg::ST_MUL0;
                    else
                        state_next = mt64_pkg::ST_SEED_READ;
                end
                else
                begin
                    unique case (phase_reg)
                        mt64_pkg::PH_LIN:
                        begin
                            cmd.seed_done = 1'b1;
                            state_next = mt64_pkg::ST_DRAW_RD0;
                        end
                        mt64_pkg::PH_PRE:
                        begin
                            cmd.arr_init = 1'b1;
                            phase_next = mt64_pkg::PH_ARR1;
                            state_next = mt64_pkg::ST_SEED_READ;
                        end
                        mt64_pkg::PH_ARR1:
                        begin
                            cmd.arr2_init = 1'b1;
                            phase_next = mt64_pkg::PH_ARR2;
                            state_next = mt64_pkg::ST_SEED_READ;
                        end
                        mt64_pkg::PH_ARR2:
                            state_next = mt64_pkg::ST_SEED_FINAL;
                        default:
                            state_next = mt64_pkg::ST_IDLE;
                    endcase
                end
            end
            mt64_pkg::ST_SEED_FINAL:
            begin
                cmd.final_wr = 1'b1;
                cmd.seed_done = 1'b1;
                state_next = mt64_pkg::ST_DRAW_RD0;
            end
            mt64_pkg::ST_DRAW_RD0:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = mt64_pkg::RD_I;
                state_next = mt64_pkg::ST_DRAW_RD1;
            end
            mt64_pkg::ST_DRAW_RD1:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = mt64_pkg::RD_I1;
                cmd.cap_a = 1'b1;
                state_next = mt64_pkg::ST_DRAW_RD2;
            end
            mt64_pkg::ST_DRAW_RD2:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = mt64_pkg::RD_IM;
                cmd.cap_b = 1'b1;
                state_next = mt64_pkg::ST_DRAW_TWIST;
            end
            mt64_pkg::ST_DRAW_TWIST:
            begin
                if (!status.out_full)
                begin
                    cmd.twist = 1'b1;
                    state_next = mt64_pkg::ST_IDLE;
                end
            end
            default:
                state_next = mt64_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> design/mt19937_64_generator_unit.sv
// MT19937-64 generator: one tempered 64-bit word per draw request. A draw on a
// seeded store goes from acceptance through three reads of the store's single
// read port, then twist and temper, and the next request is taken in the cycle
// the result appears. A draw that reseeds first adds the seeding pass, bound by
// a 32x32 multiplier used three times per word, for a single seed or for key
// array seeding. Configuration takes effect at the next reseed.
`timescale 1ns / 1ps

module mt19937_64_generator_unit #(
    parameter int KEY_WORDS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] random_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic        seed_mode_reg;
    logic [63:0] seed_value_reg;
    logic [2:0]  key_count_reg;
    logic [63:0] key_reg [KEY_WORDS];
    logic        cfg_wr;
    mt64_pkg::cfg_idx_t cfg_idx;
    mt64_pkg::dp_cmd_t cmd;
    mt64_pkg::dp_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign cfg_idx = mt64_pkg::cfg_idx_t'(paddr[5:3]);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_mode_reg <= 1'b0;
            seed_value_reg <= mt64_pkg::SEED_RESET;
            key_count_reg <= mt64_pkg::KEY_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == mt64_pkg::CFG_SEED_MODE)
                seed_mode_reg <= pwdata[0];
            if (cfg_idx == mt64_pkg::CFG_SEED_VALUE)
                seed_value_reg <= pwdata;
            if (cfg_idx == mt64_pkg::CFG_KEY_COUNT)
                key_count_reg <= pwdata[2:0];
        end
    end

    for (genvar k = 0; k < KEY_WORDS; k++)
    begin : g_key
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                key_reg[k] <= mt64_pkg::KEY_RESET[k];
            else if (cfg_wr && (3'(cfg_idx) == 3'(3 + k)))
                key_reg[k] <= pwdata;
        end
    end

    // Register read back; key words beyond KEY_WORDS and the unused index read as zero.
    always_comb
    begin
        prdata = 64'd0;
        unique case (cfg_idx)
            mt64_pkg::CFG_SEED_MODE:  prdata = {63'd0, seed_mode_reg};
            mt64_pkg::CFG_SEED_VALUE: prdata = seed_value_reg;
            mt64_pkg::CFG_KEY_COUNT:  prdata = {61'd0, key_count_reg};
            mt64_pkg::CFG_KEY_WORD0, mt64_pkg::CFG_KEY_WORD1,
            mt64_pkg::CFG_KEY_WORD2, mt64_pkg::CFG_KEY_WORD3:
            begin
                for (int k = 0; k < KEY_WORDS; k++)
                    if (3'(cfg_idx) == 3'(3 + k))
                        prdata = key_reg[k];
            end
            default:                  prdata = 64'd0;
        endcase
    end

    mt64_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .restart  (restart),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mt64_datapath #(
        .KEY_WORDS (KEY_WORDS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .seed_mode   (seed_mode_reg),
        .seed_value  (seed_value_reg),
        .key_count   (key_count_reg),
        .key_words   (key_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

endmodule

>>> design/mt64_checker.sv
// Port-level checks of the generator and their binding to the top level.
`timescale 1ns / 1ps

module mt64_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] random_word,
    input logic        pready
);

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // A request keeps the unit busy in the cycle after its transaction.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("new request taken while a draw is in flight");

    // A fresh result appears together with readiness for the next request.
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result appeared while input still stalled");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(random_word))
        else $error("stalled result changed");

endmodule

bind mt19937_64_generator_unit mt64_checker u_mt64_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word),
    .pready      (pready)
);

>>> test/mt19937_64_generator_unit_test.sv
// Self-checking testbench of the MT19937-64 generator unit with its own predictor.
`timescale 1ns / 1ps

module mt19937_64_generator_unit_test;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        restart;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] random_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    mt19937_64_generator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .restart(restart),
        .out_valid(out_valid), .out_stall(out_stall), .random_word(random_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: a copy of the registers and of the twister store.
    logic        mode_shadow;
    logic [63:0] seed_shadow;
    logic [2:0]  key_count_shadow;
    logic [63:0] key_shadow [4];
    logic [63:0] twist_store [mt64_pkg::N_WORDS];
    int unsigned draw_pos;

    logic        draw_queue [$];
    logic [63:0] expected_words [$];
    int          failures;
    int          draws_taken;
    logic        draw_taken;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    int          stall_mode_left;
    logic        stall_busy;
    logic        long_hold_done;

    // Single-seed linear fill of the store.
    function automatic void fill_from_seed(input logic [63:0] s);
        logic [63:0] p;
        twist_store[0] = s;
        for (int n = 1; n < mt64_pkg::N_WORDS; n++)
        begin
            p = twist_store[n - 1];
            twist_store[n] = mt64_pkg::LIN_MULT * (p ^ (p >> 62)) + 64'(n);
        end
    endfunction

    // Array seeding from the key words, with the key count clamped to 1..4.
    function automatic void fill_from_keys();
        int unsigned len;
        int unsigned i;
        int unsigned j;
        logic [63:0] p;
        len = key_count_shadow;
        i = 1;
        j = 0;
        if (len < 1) len = 1;
        if (len > 4) len = 4;
        fill_from_seed(mt64_pkg::ARRAY_BASE_SEED);
        for (int k = mt64_pkg::N_WORDS; k > 0; k--)
        begin
            p = twist_store[i - 1];
            twist_store[i] = (twist_store[i] ^ ((p ^ (p >> 62)) * mt64_pkg::ARR1_MULT))
                             + key_shadow[j & 3] + 64'(j);
            i++;
            j++;
            if (i >= mt64_pkg::N_WORDS)
            begin
                twist_store[0] = twist_store[mt64_pkg::N_WORDS - 1];
                i = 1;
            end
            if (j >= len) j = 0;
        end
        for (int k = mt64_pkg::N_WORDS - 1; k > 0; k--)
        begin
            p = twist_store[i - 1];
            twist_store[i] = (twist_store[i] ^ ((p ^ (p >> 62)) * mt64_pkg::ARR2_MULT))
                             - 64'(i);
            i++;
            if (i >= mt64_pkg::N_WORDS)
            begin
                twist_store[0] = twist_store[mt64_pkg::N_WORDS - 1];
                i = 1;
            end
        end
        twist_store[0] = mt64_pkg::FINAL_WORD0;
    endfunction

    // Next output word for one draw request.
    function automatic logic [63:0] next_word(input logic reseed);
        int unsigned i;
        logic [63:0] x;
        if (reseed || draw_pos >= mt64_pkg::N_WORDS)
        begin
            if (mode_shadow) fill_from_keys();
            else fill_from_seed(seed_shadow);
            draw_pos = 0;
        end
        i = draw_pos;
        x = (twist_store[i] & mt64_pkg::UPPER_MASK)
            | (twist_store[(i + 1) % mt64_pkg::N_WORDS] & mt64_pkg::LOWER_MASK);
        twist_store[i] = twist_store[(i + mt64_pkg::M_OFFSET) % mt64_pkg::N_WORDS]
                         ^ (x >> 1) ^ (x[0] ? mt64_pkg::TWIST_MATRIX : 64'd0);
        draw_pos = (i + 1) % mt64_pkg::N_WORDS;
        x = twist_store[i];
        x = x ^ ((x >> 29) & 64'h5555555555555555);
        x = x ^ ((x << 17) & 64'h71D67FFFEDA60000);
        x = x ^ ((x << 37) & 64'hFFF7EEE000000000);
        x = x ^ (x >> 43);
        return x;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #20ms;
        $display("mt19937_64_generator_unit_test failed");
        $finish;
    end

    // Prediction on accepted draw requests, checking of accepted results.
    always @(posedge clk)
    begin
        draw_taken = rst_n && in_valid && !in_stall;
        if (draw_taken)
        begin
            expected_words.push_back(next_word(restart));
            draws_taken++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("random_word: none expected, actual %h", random_word);
                failures++;
            end
            else
            begin
                logic [63:0] want;
                want = expected_words.pop_front();
                if (want !== random_word)
                begin
                    $error("random_word: expected %h, actual %h", want, random_word);
                    failures++;
                end
            end
        end
    end

    // Request driver: bursts of transactions with random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !draw_taken)
        begin
            // Hold the stalled transaction.
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            in_valid <= 1'b0;
        end
        else if (draw_queue.size() > 0)
        begin
            in_valid <= 1'b1;
            restart <= draw_queue.pop_front();
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 24);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
            else
            begin
                burst_left <= burst_left - 1;
            end
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Result stall pattern, with one long hold-off while requests keep coming.
    always @(negedge clk)
    begin
        if (!long_hold_done && draws_taken >= 120)
        begin
            long_hold_done <= 1'b1;
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (stall_mode_left == 0)
            begin
                stall_mode_left <= $urandom_range(10, 80);
                stall_busy <= $urandom_range(0, 1);
            end
            else
            begin
                stall_mode_left <= stall_mode_left - 1;
            end
            out_stall <= stall_busy && ($urandom_range(0, 2) == 0);
        end
    end

    // One register write over the configuration port, mirrored in the predictor.
    task automatic write_reg(input mt64_pkg::cfg_idx_t idx, input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            mt64_pkg::CFG_SEED_MODE:  mode_shadow = value[0];
            mt64_pkg::CFG_SEED_VALUE: seed_shadow = value;
            mt64_pkg::CFG_KEY_COUNT:  key_count_shadow = value[2:0];
            mt64_pkg::CFG_KEY_WORD0:  key_shadow[0] = value;
            mt64_pkg::CFG_KEY_WORD1:  key_shadow[1] = value;
            mt64_pkg::CFG_KEY_WORD2:  key_shadow[2] = value;
            mt64_pkg::CFG_KEY_WORD3:  key_shadow[3] = value;
            default: ;
        endcase
    endtask

    // Wait until every request is sent and every result has arrived.
    task automatic wait_drained();
        while (draw_queue.size() > 0 || in_valid || expected_words.size() > 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Queue draws; restart is raised about once per the given number of requests.
    task automatic queue_draws(input int count, input int restart_rate);
        for (int n = 0; n < count; n++)
            draw_queue.push_back($urandom_range(0, restart_rate - 1) == 0);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Stimulus: directed phases, then random configurations.
    initial
    begin
        failures = 0;
        draws_taken = 0;
        burst_left = 1;
        gap_left = 0;
        hold_left = 0;
        stall_mode_left = 0;
        stall_busy = 1'b0;
        long_hold_done = 1'b0;
        in_valid = 1'b0;
        restart = 1'b0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mode_shadow = 1'b0;
        seed_shadow = mt64_pkg::SEED_RESET;
        key_count_shadow = mt64_pkg::KEY_COUNT_RESET;
        for (int k = 0; k < 4; k++) key_shadow[k] = mt64_pkg::KEY_RESET[k];
        draw_pos = mt64_pkg::N_WORDS + 1;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Unseeded first draw without restart, then a restart among reset values.
        draw_queue.push_back(1'b0);
        draw_queue.push_back(1'b0);
        draw_queue.push_back(1'b1);
        draw_queue.push_back(1'b0);
        wait_drained();

        // Seed extremes; a write to the unused index must change nothing.
        write_reg(mt64_pkg::CFG_SEED_VALUE, 64'd0);
        write_reg(mt64_pkg::CFG_UNUSED, '1);
        draw_queue.push_back(1'b0);
        draw_queue.push_back(1'b1);
        draw_queue.push_back(1'b0);
        wait_drained();
        write_reg(mt64_pkg::CFG_SEED_VALUE, '1);
        draw_queue.push_back(1'b1);
        draw_queue.push_back(1'b0);
        wait_drained();

        // Array seeding with key count zero, above range, and each legal value.
        write_reg(mt64_pkg::CFG_SEED_MODE, 64'd1);
        write_reg(mt64_pkg::CFG_KEY_WORD0, '1);
        write_reg(mt64_pkg::CFG_KEY_WORD1, 64'd0);
        write_reg(mt64_pkg::CFG_KEY_WORD2, '1);
        write_reg(mt64_pkg::CFG_KEY_WORD3, 64'd0);
        for (int c = 0; c < 8; c++)
        begin
            write_reg(mt64_pkg::CFG_KEY_COUNT, 64'(c));
            draw_queue.push_back(1'b1);
            draw_queue.push_back(1'b0);
            wait_drained();
        end

        // Random phases; the first runs long enough to wrap the store.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(mt64_pkg::CFG_SEED_MODE, rand64());
            write_reg(mt64_pkg::CFG_SEED_VALUE, rand64());
            write_reg(mt64_pkg::CFG_KEY_COUNT, rand64());
            write_reg(mt64_pkg::CFG_KEY_WORD0, rand64());
            write_reg(mt64_pkg::CFG_KEY_WORD1, rand64());
            write_reg(mt64_pkg::CFG_KEY_WORD2, rand64());
            write_reg(mt64_pkg::CFG_KEY_WORD3, rand64());
            draw_queue.push_back(1'b1);
            if (ph == 0) queue_draws(360, 1000);
            else queue_draws(90, 40);
            wait_drained();
        end

        // Back to a single seed at the end.
        write_reg(mt64_pkg::CFG_SEED_MODE, 64'd0);
        draw_queue.push_back(1'b1);
        queue_draws(30, 10);
        wait_drained();
        repeat (20) @(negedge clk);

        if (failures == 0)
            $display("mt19937_64_generator_unit_test passed");
        else
            $display("mt19937_64_generator_unit_test failed");
        $finish;
    end

endmodule
